// ===== sv/sitda_pkg.sv =====
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared constants for the signed integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
package sitda_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int CHAR_WIDTH  = 8;
   localparam int DIGIT_WIDTH = 4;
   localparam int DIGIT_COUNT = 10;
   localparam int BCD_WIDTH   = DIGIT_COUNT * DIGIT_WIDTH;
   localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH);
   localparam int DIG_CNT_W   = $clog2(DIGIT_COUNT + 1);

   localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO  = 8'd48;
   localparam logic [CHAR_WIDTH-1:0] ASCII_MINUS = 8'd45;

   localparam logic [DIGIT_WIDTH-1:0] DABBLE_LIMIT = 4'd5;
   localparam logic [DIGIT_WIDTH-1:0] DABBLE_ADD   = 4'd3;

   typedef logic [VALUE_WIDTH-1:0] value_type;
   typedef logic [BCD_WIDTH-1:0]   bcd_type;

endpackage

// ===== sv/signed_int_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed 32-bit integer to decimal ASCII, one character per strobe.
// The sign character (if any) is strobed as the conversion ends, digits follow.
// Each request runs the shift-add-3 steps of the bit-serial binary-to-BCD
// unit, then walks the BCD digits, then returns to idle; start is ignored while busy.
// Leading zero digits are walked but strobe nothing.
// Synchronous active-high reset returns the controller to idle.
// The receiver cannot stall; each character is valid for one cycle.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic signed [sitda_pkg::VALUE_WIDTH-1:0] req_value,
   output logic                             rsp_valid,
   output logic        [sitda_pkg::CHAR_WIDTH-1:0]  rsp_char_code,
   output logic                             rsp_last_char
);
   import sitda_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_EMIT
   } state_type;

   state_type              state_ff, state_in;
   value_type              mag_ff, mag_in;
   bcd_type                bcd_ff, bcd_in;
   bcd_type                bcd_adj;
   logic [BIT_CNT_W-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [DIG_CNT_W-1:0]   dig_cnt_ff, dig_cnt_in;
   logic                   neg_ff, neg_in;
   logic                   started_ff, started_in;
   logic                   valid_ff, valid_in;
   logic [CHAR_WIDTH-1:0]  char_ff, char_in;
   logic                   last_ff, last_in;
   logic [DIGIT_WIDTH-1:0] top_digit;
   logic                   final_digit;
   logic                   show_digit;

   // add-3 correction, digits are independent lanes
   always_comb begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         if (bcd_ff[i*DIGIT_WIDTH +: DIGIT_WIDTH] >= DABBLE_LIMIT) begin
            bcd_adj[i*DIGIT_WIDTH +: DIGIT_WIDTH] =
               bcd_ff[i*DIGIT_WIDTH +: DIGIT_WIDTH] + DABBLE_ADD;
         end else begin
            bcd_adj[i*DIGIT_WIDTH +: DIGIT_WIDTH] =
               bcd_ff[i*DIGIT_WIDTH +: DIGIT_WIDTH];
         end
      end
   end

   assign top_digit   = bcd_ff[BCD_WIDTH-1 -: DIGIT_WIDTH];
   assign final_digit = (dig_cnt_ff == DIG_CNT_W'(1));
   assign show_digit  = started_ff || (top_digit != '0) || final_digit;

   always_comb begin
      state_in   = state_ff;
      mag_in     = mag_ff;
      bcd_in     = bcd_ff;
      bit_cnt_in = bit_cnt_ff;
      dig_cnt_in = dig_cnt_ff;
      neg_in     = neg_ff;
      started_in = started_ff;
      valid_in   = 1'b0;
      char_in    = char_ff;
      last_in    = last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               neg_in     = req_value[VALUE_WIDTH-1];
               mag_in     = req_value[VALUE_WIDTH-1] ? (value_type'(0) - value_type'(req_value))
                                                     : value_type'(req_value);
               bcd_in     = '0;
               bit_cnt_in = BIT_CNT_W'(VALUE_WIDTH - 1);
               state_in   = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            bcd_in     = {bcd_adj[BCD_WIDTH-2:0], mag_ff[VALUE_WIDTH-1]};
            mag_in     = {mag_ff[VALUE_WIDTH-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff - BIT_CNT_W'(1);
            if (bit_cnt_ff == '0) begin
               dig_cnt_in = DIG_CNT_W'(DIGIT_COUNT);
               started_in = 1'b0;
               state_in   = ST_EMIT;
               if (neg_ff) begin
                  valid_in = 1'b1;
                  char_in  = ASCII_MINUS;
                  last_in  = 1'b0;
               end
            end
         end
         ST_EMIT: begin
            if (show_digit) begin
               valid_in   = 1'b1;
               char_in    = ASCII_ZERO + CHAR_WIDTH'(top_digit);
               last_in    = final_digit;
               started_in = 1'b1;
            end
            bcd_in     = {bcd_ff[BCD_WIDTH-DIGIT_WIDTH-1:0], {DIGIT_WIDTH{1'b0}}};
            dig_cnt_in = dig_cnt_ff - DIG_CNT_W'(1);
            if (final_digit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         valid_ff   <= 1'b0;
         started_ff <= 1'b0;
         bit_cnt_ff <= '0;
         dig_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         valid_ff   <= valid_in;
         started_ff <= started_in;
         bit_cnt_ff <= bit_cnt_in;
         dig_cnt_ff <= dig_cnt_in;
      end
      mag_ff  <= mag_in;
      bcd_ff  <= bcd_in;
      neg_ff  <= neg_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = valid_ff;
   assign rsp_char_code = char_ff;
   assign rsp_last_char = last_ff;

endmodule
